// ===== src/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants of the character LCD nibble writer
// Job record passed from the front to the back, codes and address helpers.
// ----------------------------------------------------------------------------
package clnw_pkg;

   localparam int unsigned JOB_BYTES = 3;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] SET_ADDRESS  = 8'h80;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT    = 1'b1;

   localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
   localparam logic [2:0] ROW_COUNT_RESET    = 3'd2;

   localparam logic [3:0][6:0] LINE_OFFSET = {7'h54, 7'h14, 7'h40, 7'h00};

   typedef struct packed {
      logic [1:0]                     count;
      logic [JOB_BYTES-1:0]           rs;
      logic [JOB_BYTES-1:0][7:0]      data_bytes;
   } job_type;

   function automatic logic [1:0] fix_row(input logic [2:0] row, input logic [2:0] row_count);
      logic [1:0] res;
      if (row >= row_count || row > 3'd3) begin
         res = 2'd0;
      end else begin
         res = row[1:0];
      end
      return res;
   endfunction

   function automatic logic [7:0] set_address(input logic [5:0] col, input logic [1:0] row);
      logic [6:0] sum;
      sum = {1'b0, col} + LINE_OFFSET[row];
      return SET_ADDRESS | {1'b0, sum};
   endfunction

endpackage

// ===== src/clnw_front.sv =====
// ----------------------------------------------------------------------------
// clnw_front: cursor tracking and byte planning
// Accepts text beats, moves the cursor and plans up to three bus bytes.
// ----------------------------------------------------------------------------
module clnw_front
   import clnw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [5:0]    csr_wdata,
   input  logic          accept,
   input  logic [7:0]    character,
   input  logic          string_start,
   input  logic [5:0]    start_column,
   input  logic [2:0]    start_row,
   output job_type       job,
   output logic          job_push
);

   logic [5:0] column_count_ff, column_count_in;
   logic [2:0] row_count_ff, row_count_in;
   logic [5:0] cursor_col_ff, cursor_col_in;
   logic [1:0] cursor_row_ff, cursor_row_in;
   logic [5:0] col;
   logic [1:0] row;
   logic [1:0] n;

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_in = csr_wdata;
            CSR_ROW_COUNT:    row_count_in    = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      job = '0;
      col = cursor_col_ff;
      row = cursor_row_ff;
      n   = 2'd0;
      if (string_start) begin
         row = fix_row(start_row, row_count_ff);
         col = start_column;
         job.rs[n]         = RS_COMMAND;
         job.data_bytes[n] = set_address(col, row);
         n = n + 2'd1;
      end
      if (character != CHAR_NUL) begin
         // wrap before handling the byte
         if (col >= column_count_ff) begin
            row = fix_row(3'({1'b0, row} + 3'd1), row_count_ff);
            col = 6'd0;
            job.rs[n]         = RS_COMMAND;
            job.data_bytes[n] = set_address(col, row);
            n = n + 2'd1;
         end
         if (character == CHAR_NEWLINE) begin
            row = fix_row(3'({1'b0, row} + 3'd1), row_count_ff);
            job.rs[n]         = RS_COMMAND;
            job.data_bytes[n] = set_address(col, row);
            n = n + 2'd1;
         end else if (character == CHAR_RETURN) begin
            col = 6'd0;
            job.rs[n]         = RS_COMMAND;
            job.data_bytes[n] = set_address(col, row);
            n = n + 2'd1;
         end else begin
            job.rs[n]         = RS_DATA;
            job.data_bytes[n] = character;
            n = n + 2'd1;
            col = col + 6'd1;
         end
      end
      job.count = n;
      job_push  = accept && (n != 2'd0);
      cursor_col_in = accept ? col : cursor_col_ff;
      cursor_row_in = accept ? row : cursor_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         row_count_ff    <= ROW_COUNT_RESET;
         cursor_col_ff   <= '0;
         cursor_row_ff   <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         cursor_col_ff   <= cursor_col_in;
         cursor_row_ff   <= cursor_row_in;
      end
   end

endmodule

// ===== src/clnw_fifo.sv =====
// ----------------------------------------------------------------------------
// clnw_fifo: job queue
// Short queue of planned jobs between the front and the back.
// ----------------------------------------------------------------------------
module clnw_fifo
   import clnw_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   input  logic     pop,
   output job_type  head,
   output logic     full,
   output logic     empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full job queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty job queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("job queue count past depth");

endmodule

// ===== src/clnw_back.sv =====
// ----------------------------------------------------------------------------
// clnw_back: nibble sequencer
// Walks the head job byte by byte, high nibble first, into the output beat.
// ----------------------------------------------------------------------------
module clnw_back
   import clnw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  job_type       head,
   input  logic          empty,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [3:0]    rsp_nibble,
   output logic          rsp_rs,
   output logic          rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [3:0] nibble_ff;
   logic       rs_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       half_ff, half_in;
   logic       emit;
   logic       last;
   logic [7:0] cur_byte;
   logic [1:0] final_idx;

   assign final_idx = head.count - 2'd1;

   always_comb begin
      emit     = !empty && (!valid_ff || rsp_tready);
      cur_byte = head.data_bytes[idx_ff];
      last     = half_ff && (idx_ff == final_idx);
      pop      = emit && last;
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      idx_in   = idx_ff;
      half_in  = half_ff;
      if (emit) begin
         if (last) begin
            idx_in  = 2'd0;
            half_in = 1'b0;
         end else if (half_ff) begin
            idx_in  = idx_ff + 2'd1;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         nibble_ff <= half_ff ? cur_byte[3:0] : cur_byte[7:4];
         rs_ff     <= head.rs[idx_ff];
         last_ff   <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_nibble = nibble_ff;
   assign rsp_rs     = rs_ff;
   assign rsp_tlast  = last_ff;

   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 2'd0) && !half_ff) else $error("sequencer not rewound after pop");
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff <= final_idx) else $error("byte index past job length");
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      emit |=> valid_ff) else $error("emitted nibble not held in output");

endmodule

// ===== src/char_lcd_text_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_text_nibble_writer: text to 4-bit character LCD bus writes
// Tracks the cursor and turns text bytes into tagged nibble beats.
// ----------------------------------------------------------------------------
// A text beat is taken whenever the job queue has room, so beats may arrive
// back to back. Each beat yields 0 to 6 nibble beats: a displayed
// character gives 2, and each set-address command (string start, wrap,
// newline, carriage return) adds 2. The nibble sequencer sends one nibble
// per cycle while rsp_tready is high and a job is queued; QUEUE_DEPTH
// planned beats are buffered between the cursor logic and the sequencer.
// Configuration takes effect for beats accepted after the write.
module char_lcd_text_nibble_writer
   import clnw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [5:0]    csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // character[7:0], string_start[8], start_column[14:9], start_row[17:15]
   input  logic [23:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // nibble[3:0]
   output logic [7:0]    rsp_tdata,
   // register_select[0]
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   job_type    job;
   job_type    head;
   logic       job_push;
   logic       pop;
   logic       full;
   logic       empty;
   logic       accept;
   logic [3:0] nibble;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   clnw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .character    (req_tdata[7:0]),
      .string_start (req_tdata[8]),
      .start_column (req_tdata[14:9]),
      .start_row    (req_tdata[17:15]),
      .job          (job),
      .job_push     (job_push)
   );

   clnw_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   clnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_nibble (nibble),
      .rsp_rs     (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, nibble};

endmodule
